// ----- design/rc5_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RC5 IR sample decoder.
// No dependencies; every other design file uses it (rc5_ifs by scoped name).
package rc5_pkg;

    localparam int unsigned CODE_W   = 16;
    localparam int unsigned TIMER_W  = 8;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned PKT_W    = 5;
    localparam int unsigned CFG_DW   = 8;
    localparam int unsigned CFG_IW   = 3;

    localparam logic [TIMER_W-1:0] TIMER_MAX = 8'd255;

    // Register reset values
    localparam logic [7:0]       MIN_GAP_RST     = 8'd3;
    localparam logic [7:0]       EARLY_LIMIT_RST = 8'd6;
    localparam logic [7:0]       LATE_LIMIT_RST  = 8'd10;
    localparam logic [7:0]       PAUSE_LIMIT_RST = 8'd250;
    localparam logic [PKT_W-1:0] PACKET_BITS_RST = 5'd14;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        REG_ENABLE      = 3'd0,
        REG_MIN_GAP     = 3'd1,
        REG_EARLY_LIMIT = 3'd2,
        REG_LATE_LIMIT  = 3'd3,
        REG_PAUSE_LIMIT = 3'd4,
        REG_PACKET_BITS = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic             enable;
        logic [7:0]       min_gap;
        logic [7:0]       early_limit;
        logic [7:0]       late_limit;
        logic [7:0]       pause_limit;
        logic [PKT_W-1:0] packet_bits;
    } cfg_t;

    typedef struct packed {
        logic               last_level;
        logic [TIMER_W-1:0] bit_timer;
        logic [CODE_W-1:0]  shift_word;
        logic [COUNT_W-1:0] bit_count;
        logic [CODE_W-1:0]  latched_code;
    } dec_state_t;

endpackage

// ----- design/rc5_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command beats in, result beats out.
// Depends on rc5_pkg for payload widths.
interface rc5_cmd_if;
    logic valid;
    logic ready;
    logic operation;
    logic sample_strobe;
    logic ir_pin;

    modport source (output valid, output operation, output sample_strobe,
                    output ir_pin, input ready);
    modport sink   (input valid, input operation, input sample_strobe,
                    input ir_pin, output ready);
endinterface

interface rc5_result_if;
    logic                      valid;
    logic                      ready;
    logic [rc5_pkg::CODE_W-1:0] code;
    logic                      code_ready;

    modport source (output valid, output code, output code_ready, input ready);
    modport sink   (input valid, input code, input code_ready, output ready);
endinterface

// ----- design/rc5_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file, write-only, indexed writes.
// Depends on rc5_pkg.
module rc5_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rc5_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [rc5_pkg::CFG_DW-1:0]  cfg_data,
    output rc5_pkg::cfg_t               cfg
);
    import rc5_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ENABLE:      cfg_next.enable      = cfg_data[0];
                REG_MIN_GAP:     cfg_next.min_gap     = cfg_data;
                REG_EARLY_LIMIT: cfg_next.early_limit = cfg_data;
                REG_LATE_LIMIT:  cfg_next.late_limit  = cfg_data;
                REG_PAUSE_LIMIT: cfg_next.pause_limit = cfg_data;
                REG_PACKET_BITS: cfg_next.packet_bits = cfg_data[PKT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b0;
            cfg_reg.min_gap     <= MIN_GAP_RST;
            cfg_reg.early_limit <= EARLY_LIMIT_RST;
            cfg_reg.late_limit  <= LATE_LIMIT_RST;
            cfg_reg.pause_limit <= PAUSE_LIMIT_RST;
            cfg_reg.packet_bits <= PACKET_BITS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/rc5_step.sv -----
`timescale 1ns / 1ps
// One-beat decoder update: next state and shown code from current state.
// Purely combinational. Depends on rc5_pkg.
module rc5_step (
    input  rc5_pkg::cfg_t                cfg,
    input  rc5_pkg::dec_state_t          cur,
    input  logic                         operation,
    input  logic                         sample_strobe,
    input  logic                         ir_pin,
    output rc5_pkg::dec_state_t          nxt,
    output logic [rc5_pkg::CODE_W-1:0]   shown,
    output logic                         shown_ready
);
    import rc5_pkg::*;

    logic               level;
    logic [TIMER_W-1:0] timer_inc;

    assign level     = ~ir_pin;
    assign timer_inc = (cur.bit_timer < TIMER_MAX) ? cur.bit_timer + 8'd1 : cur.bit_timer;

    always_comb
    begin
        nxt = cur;
        if (operation == OP_READ)
        begin
            shown            = cur.latched_code;
            nxt.latched_code = '0;
        end
        else
        begin
            if (cfg.enable && sample_strobe)
            begin
                nxt.bit_timer = timer_inc;
                if (cur.last_level != level)
                begin
                    priority if (timer_inc <= cfg.min_gap)
                    begin
                        // edge too soon: drop frame, timer keeps running
                        nxt.bit_count = '0;
                    end
                    else if (cur.bit_count == '0)
                    begin
                        // start bit needs a rising sample after a long pause
                        if (level && (timer_inc > cfg.pause_limit))
                        begin
                            nxt.shift_word = 16'd1;
                            nxt.bit_count  = 8'd1;
                        end
                        else
                        begin
                            nxt.shift_word = '0;
                        end
                        nxt.bit_timer = '0;
                    end
                    else if (timer_inc >= cfg.early_limit)
                    begin
                        if (timer_inc <= cfg.late_limit)
                        begin
                            nxt.shift_word = {cur.shift_word[CODE_W-2:0], level};
                            nxt.bit_count  = cur.bit_count + 8'd1;
                        end
                        else
                        begin
                            nxt.bit_count = '0;
                        end
                        nxt.bit_timer = '0;
                    end
                    else
                    begin
                        // mid-bit edge, ignored
                        nxt.bit_count = cur.bit_count;
                    end
                end
                else if (timer_inc > cfg.late_limit)
                begin
                    if (cur.bit_count == {3'b000, cfg.packet_bits})
                        nxt.latched_code = cur.shift_word;
                    nxt.bit_count = '0;
                end
                nxt.last_level = level;
            end
            shown = nxt.latched_code;
        end
    end

    assign shown_ready = (shown != '0);

endmodule

// ----- design/rc5_ir_sample_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the RC5 IR sample decoder: command register, step logic,
// result register. Depends on rc5_pkg, rc5_ifs, rc5_cfg_regs, rc5_step.
//
//  Channel  | Dir | Handshake     | Payload
//  ---------+-----+---------------+-------------------------------------
//  cmd      | in  | valid/ready   | operation, sample_strobe, ir_pin
//  result   | out | valid/ready   | code[15:0], code_ready
//  cfg      | in  | cfg_wr_en     | cfg_index[2:0], cfg_data[7:0]
//
// Every command beat yields exactly one result beat, via the command
// register and then the result register. Throughput is one beat per
// cycle while the result side does not stall: the decoder state updates in
// the single cycle a beat moves from the command into the result register.
// Reset (rst_n low, async) clears state, empties both registers, and loads
// register defaults. A stalled result holds; the command register keeps
// accepting until it too is full.
module rc5_ir_sample_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    rc5_cmd_if.sink                     cmd,
    rc5_result_if.source                result,
    input  logic                        cfg_wr_en,
    input  logic [rc5_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [rc5_pkg::CFG_DW-1:0]  cfg_data
);
    import rc5_pkg::*;

    cfg_t cfg;

    // Command register (stage 1)
    logic s1_valid_reg;
    logic s1_operation_reg;
    logic s1_strobe_reg;
    logic s1_pin_reg;

    // Decoder state, updated as a beat enters the result register
    dec_state_t state_reg;
    dec_state_t state_next;

    // Result register (stage 2)
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_code_ready_reg;
    logic [CODE_W-1:0] code_next;
    logic              code_ready_next;

    logic out_free;
    logic s1_move;
    logic cmd_take;

    rc5_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rc5_step u_step (
        .cfg           (cfg),
        .cur           (state_reg),
        .operation     (s1_operation_reg),
        .sample_strobe (s1_strobe_reg),
        .ir_pin        (s1_pin_reg),
        .nxt           (state_next),
        .shown         (code_next),
        .shown_ready   (code_ready_next)
    );

    // Result slot frees when empty or being taken this cycle
    assign out_free  = !out_valid_reg || result.ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || out_free;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cmd_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (s1_move)
                state_reg <= state_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_operation_reg <= cmd.operation;
            s1_strobe_reg    <= cmd.sample_strobe;
            s1_pin_reg       <= cmd.ir_pin;
        end
        if (s1_move)
        begin
            out_code_reg       <= code_next;
            out_code_ready_reg <= code_ready_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.code       = out_code_reg;
    assign result.code_ready = out_code_ready_reg;

endmodule

// ----- design/rc5_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the RC5 IR sample decoder, bound to the top level.
// Depends on rc5_pkg and rc5_ir_sample_decoder.
module rc5_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [rc5_pkg::CODE_W-1:0] res_code,
    input logic                       res_code_ready
);
    import rc5_pkg::*;

    // code_ready flag tracks the code field
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_code_ready == (res_code != '0)))
        else $error("code_ready does not match code");

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_code)))
        else $error("stalled result beat changed");

    // a result appearing from empty matches a command accepted earlier
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("result beat without matching command");

    // both stages full under a stall: command side must backpressure
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(res_valid && !res_ready && cmd_valid && cmd_ready)
         && res_valid && !res_ready) |-> !cmd_ready)
        else $error("command accepted with no room");

endmodule

bind rc5_ir_sample_decoder rc5_checker u_rc5_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_code       (result.code),
    .res_code_ready (result.code_ready)
);
